// ===== rtl/biquad_df2t_filter_macros.svh =====
// Assertion macros for the biquad filter block.
`ifndef BIQUAD_DF2T_FILTER_MACROS_SVH
`define BIQUAD_DF2T_FILTER_MACROS_SVH

`ifndef SYNTH
`define BQD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bqd assertion failed");
`define BQD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bqd assertion failed");
`else
`define BQD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BQD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/bqd_pkg.sv =====
// Package for the biquad filter: widths, register indexes, microcode format and program.
`timescale 1ns / 1ps
package bqd_pkg;

  localparam int COEF_W    = 32;
  localparam int DELAY_W   = 48;
  localparam int CFG_IDX_W = 3;
  localparam int PC_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    CS_B0 = 3'd0,
    CS_B1 = 3'd1,
    CS_B2 = 3'd2,
    CS_A1 = 3'd3,
    CS_A2 = 3'd4
  } coef_sel_t;

  typedef enum logic [1:0] {
    OP_IN = 2'd0,
    OP_X  = 2'd1,
    OP_Y  = 2'd2
  } op_sel_t;

  typedef enum logic [1:0] {
    SRC_PROD = 2'd0,
    SRC_DLY1 = 2'd1,
    SRC_DLY2 = 2'd2
  } acc_src_t;

  typedef struct packed {
    logic      mul_en;
    coef_sel_t coef;
    op_sel_t   op;
    logic      acc_en;
    logic      acc_load;
    logic      acc_sub;
    acc_src_t  acc_src;
    logic      y_wr;
    logic      d1_wr;
    logic      d2_wr;
    logic      clr_jump;
    logic      last;
  } ctrl_word_t;

  localparam ctrl_word_t CW_NOP = '{
    mul_en: 1'b0, coef: CS_B0, op: OP_X, acc_en: 1'b0, acc_load: 1'b0,
    acc_sub: 1'b0, acc_src: SRC_PROD, y_wr: 1'b0, d1_wr: 1'b0, d2_wr: 1'b0,
    clr_jump: 1'b0, last: 1'b0
  };

  // Microprogram: acc = b0*x + d1 -> y; acc = b1*x + d2 - a1*y -> d1; acc = b2*x - a2*y -> d2
  function automatic ctrl_word_t ucode_word(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = CW_NOP;
    case (pc)
      3'd0: begin
        w.mul_en = 1'b1; w.coef = CS_B0; w.op = OP_IN;
        w.acc_en = 1'b1; w.acc_load = 1'b1; w.acc_src = SRC_DLY1;
        w.clr_jump = 1'b1;
      end
      3'd1: begin
        w.mul_en = 1'b1; w.coef = CS_B1; w.op = OP_X;
        w.acc_en = 1'b1; w.acc_src = SRC_PROD;
      end
      3'd2: begin
        w.acc_en = 1'b1; w.acc_load = 1'b1; w.acc_src = SRC_DLY2;
        w.y_wr = 1'b1;
      end
      3'd3: begin
        w.mul_en = 1'b1; w.coef = CS_A1; w.op = OP_Y;
        w.acc_en = 1'b1; w.acc_src = SRC_PROD;
      end
      3'd4: begin
        w.mul_en = 1'b1; w.coef = CS_B2; w.op = OP_X;
        w.acc_en = 1'b1; w.acc_sub = 1'b1; w.acc_src = SRC_PROD;
      end
      3'd5: begin
        w.mul_en = 1'b1; w.coef = CS_A2; w.op = OP_Y;
        w.acc_en = 1'b1; w.acc_load = 1'b1; w.acc_src = SRC_PROD;
        w.d1_wr = 1'b1;
      end
      3'd6: begin
        w.acc_en = 1'b1; w.acc_sub = 1'b1; w.acc_src = SRC_PROD;
      end
      3'd7: begin
        w.d2_wr = 1'b1; w.last = 1'b1;
      end
      default: w = CW_NOP;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/biquad_df2t_filter.sv =====
// Biquad IIR section, transposed direct form II, run by a microcoded sequencer.
// A filter word is taken only while idle; it runs from its accept cycle through
// the rest of an eight-word microprogram that drives a single registered 32 x
// SAMPLE_WIDTH multiplier and one accumulator; the five products share that
// multiplier, which sets the rate. The result word is loaded into the output
// register in the third step, which waits while an earlier result is untaken.
// A clear word zeroes both delays in its accept cycle and gives no result.
// Coefficients are signed Q4.COEF_FRAC_BITS; the output is rounded half up,
// saturated to SAMPLE_WIDTH bits and fed back saturated; delays saturate to 48 bits.
`timescale 1ns / 1ps
`include "biquad_df2t_filter_macros.svh"
module biquad_df2t_filter
  import bqd_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [COEF_W-1:0]              cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           kind,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out,
  output logic                           clipped
);

  localparam int PW = COEF_W + SAMPLE_WIDTH;
  localparam int AW = ((PW > DELAY_W) ? PW : DELAY_W) + 2;

  localparam logic signed [AW-1:0] HALF  = AW'(64'sd1 <<< (COEF_FRAC_BITS - 1));
  localparam logic signed [AW-1:0] Y_MAX = AW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] Y_MIN = -Y_MAX - AW'(1);
  localparam logic signed [AW-1:0] D_MAX = AW'((64'sd1 <<< (DELAY_W - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] D_MIN = -D_MAX - AW'(1);
  localparam logic signed [COEF_W-1:0] B0_RESET = COEF_W'(64'sd1 <<< COEF_FRAC_BITS);

  logic signed [COEF_W-1:0]       coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic signed [DELAY_W-1:0]      delay_one, delay_two;
  logic                           busy;
  logic [PC_W-1:0]                pc;
  logic signed [SAMPLE_WIDTH-1:0] x_reg;
  logic signed [PW-1:0]           prod;
  logic signed [AW-1:0]           acc;

  ctrl_word_t                     cw;
  logic                           in_acc, go, clr;
  logic signed [COEF_W-1:0]       mul_a;
  logic signed [SAMPLE_WIDTH-1:0] mul_b;
  logic signed [PW-1:0]           prod_next;
  logic signed [AW-1:0]           addend, acc_next;
  logic signed [AW-1:0]           rnd, shf, dly_sat;
  logic signed [SAMPLE_WIDTH-1:0] y_next;
  logic                           clip_next;

  assign cw       = ucode_word(busy ? pc : '0);
  assign in_ready = !busy;
  assign in_acc   = in_valid && in_ready;
  assign clr      = in_acc && kind && cw.clr_jump;
  assign go       = busy ? !(cw.y_wr && out_valid && !out_ready) : (in_acc && !kind);

  always_comb begin
    case (cw.coef)
      CS_B0:   mul_a = coef_b0;
      CS_B1:   mul_a = coef_b1;
      CS_B2:   mul_a = coef_b2;
      CS_A1:   mul_a = coef_a1;
      CS_A2:   mul_a = coef_a2;
      default: mul_a = coef_b0;
    endcase
    case (cw.op)
      OP_IN:   mul_b = sample_in;
      OP_X:    mul_b = x_reg;
      OP_Y:    mul_b = sample_out;
      default: mul_b = x_reg;
    endcase
    prod_next = mul_a * mul_b;
  end

  always_comb begin
    case (cw.acc_src)
      SRC_PROD: addend = AW'(prod);
      SRC_DLY1: addend = AW'(delay_one);
      SRC_DLY2: addend = AW'(delay_two);
      default:  addend = AW'(prod);
    endcase
    acc_next = (cw.acc_load ? '0 : acc) + (cw.acc_sub ? -addend : addend);
  end

  // round half up, then saturate to the sample range
  always_comb begin
    rnd = acc + HALF;
    shf = rnd >>> COEF_FRAC_BITS;
    if (shf > Y_MAX) begin
      y_next    = Y_MAX[SAMPLE_WIDTH-1:0];
      clip_next = 1'b1;
    end else if (shf < Y_MIN) begin
      y_next    = Y_MIN[SAMPLE_WIDTH-1:0];
      clip_next = 1'b1;
    end else begin
      y_next    = shf[SAMPLE_WIDTH-1:0];
      clip_next = 1'b0;
    end
    if (acc > D_MAX) begin
      dly_sat = D_MAX;
    end else if (acc < D_MIN) begin
      dly_sat = D_MIN;
    end else begin
      dly_sat = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= B0_RESET;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_B0:  coef_b0 <= cfg_data;
        REG_B1:  coef_b1 <= cfg_data;
        REG_B2:  coef_b2 <= cfg_data;
        REG_A1:  coef_a1 <= cfg_data;
        REG_A2:  coef_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pc        <= '0;
      out_valid <= 1'b0;
      delay_one <= '0;
      delay_two <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (clr) begin
        delay_one <= '0;
        delay_two <= '0;
      end
      if (go) begin
        if (cw.last) begin
          busy <= 1'b0;
          pc   <= '0;
        end else begin
          busy <= 1'b1;
          pc   <= pc + PC_W'(1);
        end
        if (cw.y_wr) begin
          out_valid <= 1'b1;
        end
        if (cw.d1_wr) begin
          delay_one <= dly_sat[DELAY_W-1:0];
        end
        if (cw.d2_wr) begin
          delay_two <= dly_sat[DELAY_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_reg <= sample_in;
    end
    if (go) begin
      if (cw.mul_en) begin
        prod <= prod_next;
      end
      if (cw.acc_en) begin
        acc <= acc_next;
      end
      if (cw.y_wr) begin
        sample_out <= y_next;
        clipped    <= clip_next;
      end
    end
  end

  `BQD_ASSERT_IMP(a_busy_pc, clk, rst, busy, pc != '0)
  `BQD_ASSERT_NXT(a_clear_delays, clk, rst, clr, (delay_one == '0) && (delay_two == '0))
  `BQD_ASSERT_NXT(a_result_load, clk, rst, busy && go && cw.y_wr, out_valid)

endmodule

// ===== tb/tb_biquad_sb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the biquad testbench: coefficient and delay shadow plus expected output words.
package tb_biquad_sb_pkg;
  import bqd_pkg::*;

  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 28;
  localparam int COEF_ONE = 1 << FRAC_W;

  localparam logic KIND_FILTER = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  localparam longint DELAY_MAX = (longint'(1) <<< (DELAY_W - 1)) - 1;
  localparam longint DELAY_MIN = -DELAY_MAX - 1;
  localparam longint Y_MAX     = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint Y_MIN     = -Y_MAX - 1;
  localparam longint HALF_LSB  = longint'(1) <<< (FRAC_W - 1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clip;
  } filt_word_t;

  class sample_scoreboard;
    logic signed [COEF_W-1:0]  coef [int'(REG_A2) + 1];
    logic signed [DELAY_W-1:0] delay_one;
    logic signed [DELAY_W-1:0] delay_two;
    filt_word_t                expected_words [$];
    int                        errors;

    function new();
      foreach (coef[i]) coef[i] = '0;
      coef[REG_B0] = COEF_W'(COEF_ONE);
      delay_one = '0;
      delay_two = '0;
      errors = 0;
    endfunction

    function void set_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
      if (idx <= REG_A2) coef[idx] = data;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function longint clamp_delay(longint v);
      if (v > DELAY_MAX) return DELAY_MAX;
      if (v < DELAY_MIN) return DELAY_MIN;
      return v;
    endfunction

    // filter step: y from b0*x + d1, then both delays updated from the saturated y
    function void note_input(logic kind, logic signed [SAMPLE_W-1:0] x);
      longint     acc;
      longint     y;
      longint     n1;
      longint     n2;
      filt_word_t w;
      if (kind == KIND_CLEAR) begin
        delay_one = '0;
        delay_two = '0;
        return;
      end
      acc = longint'(coef[REG_B0]) * longint'(x) + longint'(delay_one) + HALF_LSB;
      y = acc >>> FRAC_W;
      w.clip = 1'b0;
      if (y > Y_MAX) begin
        y = Y_MAX;
        w.clip = 1'b1;
      end
      if (y < Y_MIN) begin
        y = Y_MIN;
        w.clip = 1'b1;
      end
      w.sample = y[SAMPLE_W-1:0];
      n1 = longint'(coef[REG_B1]) * longint'(x) - longint'(coef[REG_A1]) * y
           + longint'(delay_two);
      n2 = longint'(coef[REG_B2]) * longint'(x) - longint'(coef[REG_A2]) * y;
      delay_one = DELAY_W'(clamp_delay(n1));
      delay_two = DELAY_W'(clamp_delay(n2));
      expected_words.push_back(w);
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] sample, logic clip);
      filt_word_t w;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, sample_out %0d clipped %0b", $time, sample, clip);
        return;
      end
      w = expected_words.pop_front();
      if (sample !== w.sample) begin
        errors++;
        $display("%0t: sample_out expected %0d actual %0d", $time, w.sample, sample);
      end
      if (clip !== w.clip) begin
        errors++;
        $display("%0t: clipped expected %0b actual %0b", $time, w.clip, clip);
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_biquad_df2t_filter.sv =====
`timescale 1ns / 1ps
// Testbench top for the biquad filter: directed and random samples under handshake stalls.
module tb_biquad_df2t_filter;
  import bqd_pkg::*;
  import tb_biquad_sb_pkg::*;

  localparam logic [COEF_W-1:0] COEF_MAX = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN = 32'h8000_0000;
  localparam logic [COEF_W-1:0] COEF_ZERO = 32'h0000_0000;
  localparam int DRAIN_CYCLES = 12;
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASES       = 12;
  localparam int PHASE_WORDS  = 161;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE} ready_mode_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [COEF_W-1:0]          cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       kind = KIND_FILTER;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       clipped;

  sample_scoreboard sb = new();
  int               burst_left = 0;
  int               idle_cycles = 0;
  int               mode_left = 0;
  ready_mode_t      ready_mode = RDY_ALWAYS;

  biquad_df2t_filter #(
    .SAMPLE_WIDTH(SAMPLE_W),
    .COEF_FRAC_BITS(FRAC_W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .sample_in(sample_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sample_out(sample_out),
    .clipped(clipped)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // drain: hold off until every expected word is back
  task automatic send_word(logic k, logic signed [SAMPLE_W-1:0] x, int gap, bit drain);
    if (drain && gap == 0) gap = 1;
    if (gap > 0) begin
      in_valid <= 1'b0;
      while (drain && sb.pending() != 0) @(posedge clk);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    sample_in <= x;
    do @(posedge clk); while (!in_ready);
    sb.note_input(k, x);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_coefs(logic [COEF_W-1:0] b0, logic [COEF_W-1:0] b1,
                               logic [COEF_W-1:0] b2, logic [COEF_W-1:0] a1,
                               logic [COEF_W-1:0] a2);
    logic [COEF_W-1:0]    vals [5];
    logic [CFG_IDX_W-1:0] idx;
    vals = '{b0, b1, b2, a1, a2};
    for (int i = REG_B0; i <= REG_A2; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_coef(CFG_IDX_W'(i), vals[i]);
    end
    // unmapped index, must be ignored
    idx = CFG_IDX_W'($urandom_range(int'(REG_A2) + 1, 2 ** CFG_IDX_W - 1));
    vals[0] = $urandom;
    cfg_index <= idx;
    cfg_data <= vals[0];
    @(posedge clk);
    sb.set_coef(idx, vals[0]);
    cfg_we <= 1'b0;
  endtask

  function automatic int next_gap(bit bursty);
    if (!bursty) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 20);
    return $urandom_range(1, 12);
  endfunction

  function automatic logic [COEF_W-1:0] rand_unit();
    return COEF_W'(int'($urandom_range(0, 2 * COEF_ONE)) - COEF_ONE);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2, 3: return SAMPLE_W'($urandom_range(0, 512) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(sample_out, clipped);
    if (mode_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(RDY_ALWAYS, RDY_SPARSE));
      mode_left = $urandom_range(8, 80);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_COIN: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("tb_biquad_df2t_filter: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    longint a1;
    longint a2;
    longint lim;
    logic   k;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset coefficients: pass-through
    send_word(KIND_FILTER, 16'sh8000, 0, 0);
    send_word(KIND_FILTER, 16'sh7FFF, 0, 0);
    send_word(KIND_FILTER, 16'sh0000, 0, 0);
    send_word(KIND_FILTER, 16'sh0001, 0, 0);
    send_word(KIND_FILTER, 16'shFFFF, 0, 0);
    send_word(KIND_CLEAR, 16'sh1234, 0, 0);
    wait_idle();

    // b0 = 0.5: half-LSB rounding goes toward plus infinity
    program_coefs(COEF_W'(COEF_ONE / 2), COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
    send_word(KIND_FILTER, 16'sh0001, 0, 0);
    send_word(KIND_FILTER, 16'shFFFF, 0, 0);
    send_word(KIND_FILTER, 16'sh0003, 0, 0);
    send_word(KIND_FILTER, 16'shFFFD, 0, 0);
    wait_idle();

    // extreme coefficients: output clipping and delay saturation, clear with full delays
    program_coefs(COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX);
    send_word(KIND_FILTER, 16'sh7FFF, 0, 0);
    send_word(KIND_FILTER, 16'sh8000, 0, 0);
    send_word(KIND_FILTER, 16'sh7FFF, 0, 0);
    send_word(KIND_CLEAR, 16'sh8000, 0, 0);
    send_word(KIND_FILTER, 16'sh0000, 0, 0);
    send_word(KIND_FILTER, 16'sh8000, 0, 0);
    wait_idle();

    program_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    send_word(KIND_FILTER, 16'sh8000, 0, 0);
    send_word(KIND_FILTER, 16'sh7FFF, 0, 0);
    send_word(KIND_FILTER, 16'sh8000, 0, 0);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p % 4)
        1: program_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
        2: program_coefs(rand_unit(), rand_unit(), rand_unit(), COEF_ZERO, COEF_ZERO);
        default: begin
          // stable pole pair: |a2| < 1, |a1| < 1 + a2
          a2 = longint'($urandom_range(0, 495000000)) - 240000000;
          lim = (longint'(COEF_ONE) + a2) * 19 / 20;
          a1 = longint'($urandom_range(0, 32'(2 * lim))) - lim;
          program_coefs(rand_unit(), rand_unit(), rand_unit(), COEF_W'(a1), COEF_W'(a2));
        end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        k = ($urandom_range(0, 19) == 0) ? KIND_CLEAR : KIND_FILTER;
        send_word(k, rand_sample(), next_gap(p % 3 != 0),
                  n == PHASE_WORDS / 2 || $urandom_range(0, 199) == 0);
      end
    end
    wait_idle();

    if (sb.errors == 0) begin
      $display("tb_biquad_df2t_filter: PASS");
    end else begin
      $display("tb_biquad_df2t_filter: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bqd_pkg.sv
rtl/biquad_df2t_filter.sv
tb/tb_biquad_sb_pkg.sv
tb/tb_biquad_df2t_filter.sv
